/* rtl/core/sound_register_log_encoder_core_assert.svh */
// Assertion macros shared by the checker of the sound register log encoder.
// Depends on nothing; included by the checker file by its bare name.
`ifndef SOUND_REGISTER_LOG_ENCODER_CORE_ASSERT_SVH
`define SOUND_REGISTER_LOG_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

// Implication that is checked during reset as well.
`define SLRE_ASSERT_ALWAYS(label, clk, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/slre_pkg.sv */
// Package of the sound register log encoder: request codes, log byte codes,
// the command record passed from the front to the back, and the back FSM states.
// Depends on nothing.
package slre_pkg;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_END   = 2'd2;

	localparam logic [7:0] SYNC_ONE   = 8'hFF;
	localparam logic [7:0] SYNC_MANY  = 8'hFE;
	localparam logic [7:0] END_MARK   = 8'hFD;
	localparam logic [7:0] DIGIT_MORE = 8'h80;
	localparam logic [6:0] DIGIT_MASK = 7'h7F;

	// Ticks left pending by the file open: padding plus the first event.
	localparam int TICK_PAD   = 10;
	localparam int TICK_RESET = TICK_PAD + 1;

	typedef struct packed {
		logic       is_end;
		logic [7:0] module_id;
		logic [7:0] reg_addr;
		logic [7:0] reg_value;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	typedef enum logic [2:0] {
		B_START,
		B_FF_LAST,
		B_DIG,
		B_CMD,
		B_ADDR,
		B_VAL
	} back_state_t;

endpackage

/* rtl/core/slre_queue.sv */
// Small FIFO between the front and the back of the log encoder.
// Depends on nothing; the entry width and depth are parameters.
module slre_queue #(
	parameter int WIDTH = 57,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      fill_q;

	assign full  = (fill_q == (AW+1)'(DEPTH));
	assign empty = (fill_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/slre_front.sv */
// Front of the log encoder: accepts request words, counts ticks and queues
// writes and end marks with the tick count to flush. Depends on slre_pkg.
module slre_front #(
	parameter int TICK_COUNT_BITS = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [23:0]                               s_tdata,
	input  logic [1:0]                                s_tuser,
	input  logic                                      q_full,
	output logic                                      push,
	output logic [TICK_COUNT_BITS+slre_pkg::CMD_W-1:0] push_data
);
	import slre_pkg::*;

	logic [TICK_COUNT_BITS-1:0] count_q;
	logic                       log_open_q;
	logic                       accept;
	logic                       is_cmd;
	cmd_t                       cmd;

	// Once the log is closed, words are swallowed without a queue slot.
	assign s_tready = !log_open_q || !q_full;
	assign accept   = s_tvalid && s_tready && log_open_q;
	assign is_cmd   = (s_tuser == REQ_WRITE) || (s_tuser == REQ_END);
	assign push     = accept && is_cmd;

	always_comb begin
		cmd.is_end    = (s_tuser == REQ_END);
		cmd.module_id = s_tdata[7:0];
		cmd.reg_addr  = s_tdata[15:8];
		cmd.reg_value = s_tdata[23:16];
	end

	assign push_data = {count_q, cmd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= TICK_COUNT_BITS'(TICK_RESET);
			log_open_q <= 1'b1;
		end else if (accept) begin
			if (s_tuser == REQ_TICK) begin
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
			end else if (is_cmd) begin
				count_q <= '0;
				if (s_tuser == REQ_END) begin
					log_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/core/slre_back.sv */
// Back of the log encoder: turns a queued command into sync, digit and command
// bytes, one per cycle unless stalled, via an output register. Depends on slre_pkg.
module slre_back #(
	parameter int TICK_COUNT_BITS = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic [TICK_COUNT_BITS+slre_pkg::CMD_W-1:0] head,
	input  logic                                      q_empty,
	output logic                                      pop,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [7:0]                                m_tdata,
	output logic                                      m_tlast
);
	import slre_pkg::*;

	localparam int TW = TICK_COUNT_BITS;

	back_state_t   state_q, state_d;
	logic [TW-1:0] rem_q, rem_d;
	logic [TW-1:0] cnt;
	cmd_t          cmd;
	logic          can_load;
	logic          emit;
	logic          more;
	logic [7:0]    byte_d;
	logic          last_d;
	logic          done;
	logic          m_tvalid_q;
	logic [7:0]    m_tdata_q;
	logic          m_tlast_q;

	assign cmd      = head[CMD_W-1:0];
	assign cnt      = head[TW+CMD_W-1:CMD_W];
	assign can_load = !m_tvalid_q || m_tready;
	assign emit     = can_load && ((state_q != B_START) || !q_empty);
	assign more     = (rem_q[TW-1:7] != '0);
	assign pop      = emit && done;

	// Next state and the base-128 remainder.
	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		if (emit) begin
			unique case (state_q)
				B_START: begin
					if (cnt == '0) begin
						state_d = cmd.is_end ? B_START : B_ADDR;
					end else if (cnt == TW'(1)) begin
						state_d = B_CMD;
					end else if (cnt == TW'(2)) begin
						state_d = B_FF_LAST;
					end else begin
						state_d = B_DIG;
						rem_d   = cnt - TW'(2);
					end
				end
				B_FF_LAST: state_d = B_CMD;
				B_DIG: begin
					if (more) begin
						rem_d = rem_q >> 7;
					end else begin
						state_d = B_CMD;
					end
				end
				B_CMD:  state_d = cmd.is_end ? B_START : B_ADDR;
				B_ADDR: state_d = B_VAL;
				B_VAL:  state_d = B_START;
				default: state_d = B_START;
			endcase
		end
	end

	// Byte emitted in the current state and whether it ends the command.
	always_comb begin
		byte_d = SYNC_ONE;
		last_d = 1'b0;
		done   = 1'b0;
		unique case (state_q)
			B_START: begin
				if (cnt == '0) begin
					if (cmd.is_end) begin
						byte_d = END_MARK;
						last_d = 1'b1;
						done   = 1'b1;
					end else begin
						byte_d = cmd.module_id;
					end
				end else if ((cnt == TW'(1)) || (cnt == TW'(2))) begin
					byte_d = SYNC_ONE;
				end else begin
					byte_d = SYNC_MANY;
				end
			end
			B_FF_LAST: byte_d = SYNC_ONE;
			B_DIG: begin
				byte_d = more ? (DIGIT_MORE | {1'b0, rem_q[6:0] & DIGIT_MASK})
				              : {1'b0, rem_q[6:0] & DIGIT_MASK};
			end
			B_CMD: begin
				if (cmd.is_end) begin
					byte_d = END_MARK;
					last_d = 1'b1;
					done   = 1'b1;
				end else begin
					byte_d = cmd.module_id;
				end
			end
			B_ADDR: byte_d = cmd.reg_addr;
			B_VAL: begin
				byte_d = cmd.reg_value;
				last_d = 1'b1;
				done   = 1'b1;
			end
			default: byte_d = SYNC_ONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_START;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (can_load) begin
				m_tvalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		if (can_load) begin
			m_tdata_q <= byte_d;
			m_tlast_q <= last_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

/* rtl/core/sound_register_log_encoder_core.sv */
// Top level of the sound register log encoder core.
// Depends on slre_pkg, slre_front, slre_queue and slre_back.
//
// The slave channel takes request words: s_tuser carries the request kind
// (timer tick, register write or end of log) and s_tdata the write fields.
// The master channel gives the log stream one byte per word; m_tlast marks
// the final byte caused by a request. Ticks only count and produce nothing.
// A write produces the flushed tick code (none, one or two 0xFF, or 0xFE and
// up to five base-128 digits) followed by module, address and data bytes, so
// three to nine words. An end of log produces the flush and 0xFD, then closes
// the log: every later request is taken and dropped.
//
// The front takes a word while the queue has room. Each command then waits
// in a two-entry queue; the back sequencer emits one byte per cycle into the
// output register while m_tready allows. The first byte of a command passes
// through the queue and then the output register. Throughput is bounded by
// the back sequencer: one output byte per cycle while m_tready allows.
//
// Reset clears the queue and output register and leaves eleven ticks pending.
// When the receiver stalls, the output word holds; the queue fills and then
// s_tready drops until the back frees an entry.
module sound_register_log_encoder_core #(
	parameter int TICK_COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // module_id [7:0], reg_addr [15:8], reg_value [23:16]
	input  logic [1:0]  s_tuser,   // req_type [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte [7:0]
	output logic        m_tlast    // last_byte
);
	import slre_pkg::*;

	// Each queue entry is the tick count to flush above the command record.
	localparam int ENTRY_W = TICK_COUNT_BITS + CMD_W;

	logic               q_full;
	logic               q_empty;
	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] push_data;
	logic [ENTRY_W-1:0] head;

	slre_front #(
		.TICK_COUNT_BITS(TICK_COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	slre_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	slre_back #(
		.TICK_COUNT_BITS(TICK_COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

/* rtl/core/slre_checker.sv */
// Port-level checker for the sound register log encoder core, bound to the top.
// Depends on sound_register_log_encoder_core_assert.svh.
`include "sound_register_log_encoder_core_assert.svh"

module slre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	// A stalled output word keeps its byte and marker.
	`SLRE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// The output register is empty while reset is held.
	`SLRE_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n, !m_tvalid)

	// Inside a command the sequencer never leaves a gap in the byte stream.
	`SLRE_ASSERT_NEXT(a_no_gap, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)

	// Backpressure only arises while the back end has a word on offer.
	`SLRE_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !s_tready, m_tvalid)

endmodule

bind sound_register_log_encoder_core slre_checker u_slre_checker (.*);
